// ----- rtl/ts_pid_filter_defines.svh -----
// Assertion macros shared by the transport stream PID filter checkers.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef TS_PID_FILTER_DEFINES_SVH
`define TS_PID_FILTER_DEFINES_SVH

// Implication within the same cycle, sampled on the rising clock edge, off during reset.
`define TSPF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication into the next cycle, sampled on the rising clock edge, off during reset.
`define TSPF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tspf_pkg.sv -----
// Package for the transport stream PID filter: constants, the result type and the
// push bundle that passes from the packet parser to the output queue. No dependencies.
package tspf_pkg;

	// Stream format.
	localparam int unsigned PACKET_BYTES = 188;
	localparam logic [7:0] SYNC_VALUE = 8'h47;
	localparam int unsigned PID_W = 13;
	localparam int unsigned POS_W = 8;

	// Byte positions with a special meaning inside a packet.
	localparam logic [POS_W-1:0] POS_HUNT = 8'd0;
	localparam logic [POS_W-1:0] POS_PID_HI = 8'd1;
	localparam logic [POS_W-1:0] POS_PID_LO = 8'd2;

	// Results caused by one input item at most, and the output queue that holds them.
	localparam int unsigned MAX_RESULTS = 3;
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);
	localparam int unsigned PUSH_W = $clog2(MAX_RESULTS + 1);

	// One result item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       packet_start;
		logic       run_last;
	} tspf_result_t;

	// Results produced by one accepted input item, in order from index 0.
	typedef struct packed {
		logic [PUSH_W-1:0]                  count;
		tspf_result_t [MAX_RESULTS-1:0]     res;
	} tspf_push_t;

endpackage

// ----- rtl/tspf_parse.sv -----
// Packet parser of the PID filter: sync hunting, header capture, PID match and body pass.
// Depends on tspf_pkg.
module tspf_parse (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [12:0]            cfg_wdata,
	input  logic                   in_accept,
	input  logic [7:0]             in_byte,
	output tspf_pkg::tspf_push_t   push
);
	import tspf_pkg::*;

	logic [PID_W-1:0] target_pid_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       held_hi_q;
	logic             passing_q;

	logic [POS_W-1:0] pos_d;
	logic [POS_W-1:0] pos_inc;
	logic [7:0]       held_hi_d;
	logic             passing_d;
	logic             pid_match;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_pid_q <= '0;
		end else if (cfg_we) begin
			target_pid_q <= cfg_wdata;
		end
	end

	assign pid_match = ({held_hi_q[4:0], in_byte} == target_pid_q);
	assign pos_inc = pos_q + POS_W'(1);

	// Next state and the results for the item on the input.
	always_comb begin
		pos_d = pos_q;
		held_hi_d = held_hi_q;
		passing_d = passing_q;
		push = '0;
		if (in_accept) begin
			if (pos_q == POS_HUNT) begin
				if (in_byte == SYNC_VALUE) begin
					pos_d = POS_PID_HI;
					passing_d = 1'b0;
				end
			end else begin
				if (pos_q == POS_PID_HI) begin
					held_hi_d = in_byte;
				end else if (pos_q == POS_PID_LO) begin
					passing_d = pid_match;
					if (pid_match) begin
						push.count = PUSH_W'(3);
						push.res[0] = '{out_byte: SYNC_VALUE, packet_start: 1'b1,
							run_last: 1'b0};
						push.res[1] = '{out_byte: held_hi_q, packet_start: 1'b0,
							run_last: 1'b0};
						push.res[2] = '{out_byte: in_byte, packet_start: 1'b0,
							run_last: 1'b1};
					end
				end else if (passing_q) begin
					push.count = PUSH_W'(1);
					push.res[0] = '{out_byte: in_byte, packet_start: 1'b0, run_last: 1'b1};
				end
				// The packet ends after its last byte and hunting starts again.
				if (pos_inc >= POS_W'(PACKET_BYTES)) begin
					pos_d = POS_HUNT;
					passing_d = 1'b0;
				end else begin
					pos_d = pos_inc;
				end
			end
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
			held_hi_q <= '0;
			passing_q <= 1'b0;
		end else begin
			pos_q <= pos_d;
			held_hi_q <= held_hi_d;
			passing_q <= passing_d;
		end
	end

endmodule

// ----- rtl/tspf_outq.sv -----
// Output queue of the PID filter: takes up to three results per cycle and hands out one when the output is ready.
// Depends on tspf_pkg.
module tspf_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tspf_pkg::tspf_push_t   push,
	output logic                   space_ok,
	output logic                   out_valid,
	input  logic                   out_ready,
	output tspf_pkg::tspf_result_t out_res
);
	import tspf_pkg::*;

	tspf_result_t       entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               pop;

	// Room for a whole header run is needed before the next item is taken.
	assign space_ok = (count_q <= Q_CNT_W'(Q_DEPTH - MAX_RESULTS));
	assign out_valid = (count_q != '0);
	assign out_res = entry_q[rd_ptr_q];
	assign pop = out_valid && out_ready;

	// Result storage; entries are written in order from the write pointer.
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (PUSH_W'(i) < push.count) begin
				entry_q[wr_ptr_q + Q_PTR_W'(i)] <= push.res[i];
			end
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_PTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + Q_PTR_W'(pop);
			count_q <= count_q + Q_CNT_W'(push.count) - Q_CNT_W'(pop);
		end
	end

endmodule

// ----- rtl/ts_pid_filter.sv -----
// Top level of the transport stream PID filter: packet parser feeding an output queue.
// Depends on tspf_pkg, tspf_parse and tspf_outq.
//
//   Channel  Direction  Ports                          Item
//   s        in         s_tvalid s_tready s_tdata      one raw stream byte
//   m        out        m_tvalid m_tready m_tdata ...  one byte of a matching packet
//   cfg      in         cfg_we cfg_wdata               target PID write
//
// One input item is taken per cycle while the output queue holds at most one result.
// A result reaches m only through the registered output queue, never straight from s.
// The header of a matching packet puts three results into the four-entry queue at once,
// so the input is held off until the queue has drained back to one result.
// Reset clears the parser to sync hunting, the target PID to zero and empties the queue.
// A stall on m fills the queue and then holds off s; no item is lost.
module ts_pid_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata,   // target_pid
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,     // out_byte
	output logic        m_tuser,     // packet_start
	output logic        m_tlast      // run_last
);
	import tspf_pkg::*;

	tspf_push_t   push;
	tspf_result_t out_res;
	logic         space_ok;
	logic         in_accept;

	assign s_tready = space_ok;
	assign in_accept = s_tvalid && space_ok;

	// Packet parsing and PID match.
	tspf_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_accept (in_accept),
		.in_byte   (s_tdata),
		.push      (push)
	);

	// Result queue towards the output channel.
	tspf_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space_ok  (space_ok),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = out_res.out_byte;
	assign m_tuser = out_res.packet_start;
	assign m_tlast = out_res.run_last;

endmodule

// ----- rtl/tspf_checker.sv -----
// Port-level checker for the PID filter and the bind that attaches it to the top level.
// Depends on tspf_pkg and ts_pid_filter_defines.svh.
`include "ts_pid_filter_defines.svh"

module tspf_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast
);
	import tspf_pkg::*;

	// A packet start is always the sync byte and never ends a header run.
	`TSPF_ASSERT_SAME(a_start_is_sync, m_tvalid && m_tuser, m_tdata == SYNC_VALUE && !m_tlast, "packet start item is not a sync byte opening a run")

	// The rest of a header run is already queued when its first item leaves.
	`TSPF_ASSERT_NEXT(a_header_follows, m_tvalid && m_tready && m_tuser, m_tvalid && !m_tuser && !m_tlast, "header run broken after its sync byte")

	// When an item taken into an empty queue brings a header run, the input is held off while its sync byte is offered.
	`TSPF_ASSERT_NEXT(a_hold_after_header, s_tvalid && s_tready && !m_tvalid, !(m_tvalid && m_tuser) || !s_tready, "input taken while a header run is queued")

	// A stalled result stays offered.
	`TSPF_ASSERT_NEXT(a_out_holds, m_tvalid && !m_tready, m_tvalid, "output item withdrawn while stalled")

endmodule

bind ts_pid_filter tspf_checker u_tspf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
